FILE: rtl/ssd_mux_pkg.sv
// Shared types, constants and tables for the seven-segment digit multiplexer.
package ssd_mux_pkg;

    localparam int NUM_DIGITS     = 5;
    localparam int POS_W          = 3;
    localparam int VALUE_W        = 18;
    localparam int LIMIT_W        = 17;
    localparam int SEG_W          = 7;
    localparam int CFG_INDEX_W    = 2;
    localparam int FRAC_BITS      = 34;
    localparam int RECIP_W        = 31;
    localparam int PROD_W         = LIMIT_W + RECIP_W;

    localparam logic [POS_W-1:0] UNITS_POSITION    = POS_W'(2);
    localparam logic [POS_W-1:0] HUNDREDS_POSITION = POS_W'(NUM_DIGITS - 1);

    localparam logic [LIMIT_W-1:0] MIN_VALUE_RESET = LIMIT_W'(0);
    localparam logic [LIMIT_W-1:0] MAX_VALUE_RESET = LIMIT_W'(99999);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_VALUE = 2'd0,
        CFG_MAX_VALUE = 2'd1
    } t_cfg_index;

    // ceil(2^34 / (10 * 10^position)): the fraction of the product gives the digit
    localparam logic [RECIP_W-1:0] RECIP_TABLE [NUM_DIGITS] = '{
        31'd1717986919,
        31'd171798692,
        31'd17179870,
        31'd1717987,
        31'd171799
    };

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_hundredths;
        logic [POS_W-1:0]          digit_position;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0]      segments;
        logic                  decimal_point;
        logic [NUM_DIGITS-1:0] digit_enable;
        logic [POS_W-1:0]      used_position;
    } t_out_item;

    // Clamped value and position (forced to zero when out of range) held between the two stages
    typedef struct packed {
        logic [LIMIT_W-1:0] value;
        logic [POS_W-1:0]   pos;
    } t_stage;

endpackage

FILE: rtl/ssd_mux_decode.sv
// Digit extraction and segment decode for one clamped value and position.
module ssd_mux_decode (
    input  ssd_mux_pkg::t_stage    i_stage,
    output ssd_mux_pkg::t_out_item o_item
);
    import ssd_mux_pkg::*;

    logic [PROD_W-1:0]      prod;
    logic [FRAC_BITS:0]     frac;
    logic [FRAC_BITS+4:0]   scaled;
    logic [4:0]             digit;

    always_comb begin
        prod = PROD_W'(i_stage.value) * PROD_W'(RECIP_TABLE[i_stage.pos]);
        // keep the integer bit for the hundreds place, which has no modulo
        if (i_stage.pos == HUNDREDS_POSITION) begin
            frac = prod[FRAC_BITS:0];
        end else begin
            frac = {1'b0, prod[FRAC_BITS-1:0]};
        end
        scaled = (FRAC_BITS + 5)'({frac, 3'b000}) + (FRAC_BITS + 5)'({frac, 1'b0});
        digit  = scaled[FRAC_BITS+4:FRAC_BITS];

        if (digit < 5'd10) begin
            o_item.segments = SEG_TABLE[digit[3:0]];
        end else begin
            o_item.segments = '0;
        end
        o_item.decimal_point = (i_stage.pos == UNITS_POSITION);
        o_item.digit_enable  = NUM_DIGITS'(1) << (HUNDREDS_POSITION - i_stage.pos);
        o_item.used_position = i_stage.pos;
    end

endmodule

FILE: rtl/seven_segment_digit_mux.sv
// Throughput: one item per cycle while the output is not stalled; the input
// clamp feeds the stage register, and the reciprocal multiply with segment
// lookup feeds the result register.
// A stalled result register backs up the stage register, then the input.
// Reset (synchronous, active low) empties both stages and restores the limits
// to 0 and 99999.
module seven_segment_digit_mux (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ssd_mux_pkg::t_in_item                i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ssd_mux_pkg::t_out_item               o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [ssd_mux_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ssd_mux_pkg::LIMIT_W-1:0]      i_cfg_wdata
);
    import ssd_mux_pkg::*;

    logic [LIMIT_W-1:0] r_min_value;
    logic [LIMIT_W-1:0] r_max_value;
    logic               r_a_valid;
    t_stage             r_a;
    logic               r_b_valid;
    t_out_item          r_b;

    t_stage             n_a;
    t_out_item          n_b;
    logic signed [VALUE_W-1:0] clamped;
    logic               a_ready;
    logic               b_ready;

    assign b_ready    = !r_b_valid || i_out_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_in_ready = a_ready;

    always_comb begin
        clamped = i_in_data.value_hundredths;
        if (clamped < $signed({1'b0, r_min_value})) begin
            clamped = $signed({1'b0, r_min_value});
        end
        // upper limit wins when the limits cross
        if (clamped > $signed({1'b0, r_max_value})) begin
            clamped = $signed({1'b0, r_max_value});
        end
        n_a.value = clamped[LIMIT_W-1:0];
        if (i_in_data.digit_position > HUNDREDS_POSITION) begin
            n_a.pos = '0;
        end else begin
            n_a.pos = i_in_data.digit_position;
        end
    end

    ssd_mux_decode u_decode (
        .i_stage (r_a),
        .o_item  (n_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value <= MIN_VALUE_RESET;
            r_max_value <= MAX_VALUE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_VALUE: r_min_value <= i_cfg_wdata;
                CFG_MAX_VALUE: r_max_value <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && a_ready) begin
            r_a <= n_a;
        end
        if (r_a_valid && b_ready) begin
            r_b <= n_b;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_out_data  = r_b;

    // Hold the stage register while the result side is blocked
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_ready |=> r_a_valid && $stable(r_a))
        else $error("stage register changed while stalled");

    out_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_out_data.digit_enable) &&
            o_out_data.used_position <= HUNDREDS_POSITION)
        else $error("digit enable not one-hot or position out of range");

    out_point_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.decimal_point ==
            (o_out_data.used_position == UNITS_POSITION))
        else $error("decimal point does not match driven position");

endmodule
